>>> src/cfsr_pkg.sv
// Package: constants, opcodes and sequencer states for the frame sync receiver.
`timescale 1ns / 1ps
`default_nettype none
package cfsr_pkg;
   localparam int BUF_DEPTH = 8192;
   localparam int ADDR_W = $clog2(BUF_DEPTH);
   localparam int CNT_W = $clog2(BUF_DEPTH + 1);
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_READ = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NOP = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_MAGIC_FIRST = 2'd0,
      CSR_MAGIC_SECOND = 2'd1,
      CSR_MAX_PAYLOAD = 2'd2,
      CSR_MAX_OUT = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OP,
      ST_RDWAIT,
      ST_SCAN,
      ST_HDR_REQ,
      ST_HDR_WAIT,
      ST_HDR_CHECK,
      ST_CRC_REQ,
      ST_CRC_WAIT,
      ST_CRC_BIT,
      ST_CRC_CMP,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

>>> src/crc_framed_stream_resync_receiver.sv
// Top level: byte store, frame hunt sequencer and bit-serial CRC unit.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tdata {payload_index, rx_byte, opcode}
//  rsp     | out | rsp_tvalid/tready  | tdata {fill_level, read_data, frame_length,
//          |     |                    |        frame_ready, byte_taken}
//  csr     | in  | csr_valid/ready    | csr_index, csr_data
//
// One request at a time; ready returns once the response is in the output register.
// Push/release pass through op, scan check and done after accept; a read also waits on the store.
// The scan drops a byte on a bad first or second magic byte, a failed header check or a
// CRC mismatch; a CRC check reads each byte of magic+length+payload and runs it through
// the CRC shifter, one bit per cycle, then reads the two CRC bytes and compares.
// Reset is synchronous and clears control state; the byte store is not cleared.
// The response register stalls the sequencer only in the DONE state.
`timescale 1ns / 1ps
`default_nettype none
module crc_framed_stream_resync_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // opcode[1:0], rx_byte[9:2], payload_index[21:10]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // byte_taken[0], frame_ready[1], frame_length[13:2],
                                        // read_data[21:14], fill_level[35:22]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_data
);
   localparam int AW = cfsr_pkg::ADDR_W;
   localparam int CW = cfsr_pkg::CNT_W;

   logic [7:0] mem [cfsr_pkg::BUF_DEPTH];
   logic [7:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic rd_en;
   logic wr_en;
   logic [AW-1:0] wr_addr;

   cfsr_pkg::state_type state_ff, state_in;
   logic [7:0]  magic1_ff, magic2_ff;
   logic [11:0] max_pl_ff, max_out_ff;
   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic held_ff, held_in;
   logic [11:0] hlen_ff, hlen_in;
   logic [1:0]  op_ff, op_in;
   logic [7:0]  rx_ff, rx_in;
   logic [11:0] idx_ff, idx_in;
   logic taken_ff, taken_in;
   logic [7:0] data_ff, data_in;
   logic [2:0] hcnt_ff, hcnt_in;
   logic [7:0] h2_ff, h2_in, h3_ff, h3_in;
   logic [12:0] pos_ff, pos_in;
   logic [2:0] bit_ff, bit_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0] cbyte_ff, cbyte_in;
   logic [15:0] rcrc_ff, rcrc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   logic [11:0] plen, caplen;
   logic [12:0] crc_n;
   logic [13:0] flen;

   assign plen = {h2_ff[3:0], h3_ff};
   assign crc_n = 13'd4 + {1'b0, hlen_ff};
   assign flen = 14'd6 + {2'b0, plen};
   assign caplen = !held_ff ? 12'd0 : ((hlen_ff <= max_out_ff) ? hlen_ff : max_out_ff);

   assign req_tready = (state_ff == cfsr_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign wr_addr = front_ff + count_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= rx_ff;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfsr_pkg::ST_IDLE;
         magic1_ff <= 8'h55;
         magic2_ff <= 8'hAA;
         max_pl_ff <= 12'hFFF;
         max_out_ff <= 12'hFFF;
         front_ff <= '0;
         count_ff <= '0;
         held_ff <= 1'b0;
         hlen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         held_ff <= held_in;
         hlen_ff <= hlen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (cfsr_pkg::csr_index_type'(csr_index))
               cfsr_pkg::CSR_MAGIC_FIRST: magic1_ff <= csr_data[7:0];
               cfsr_pkg::CSR_MAGIC_SECOND: magic2_ff <= csr_data[7:0];
               cfsr_pkg::CSR_MAX_PAYLOAD: max_pl_ff <= csr_data;
               cfsr_pkg::CSR_MAX_OUT: max_out_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; rx_ff <= rx_in; idx_ff <= idx_in;
      taken_ff <= taken_in; data_ff <= data_in;
      hcnt_ff <= hcnt_in; h2_ff <= h2_in; h3_ff <= h3_in;
      pos_ff <= pos_in; bit_ff <= bit_in; crc_ff <= crc_in; cbyte_ff <= cbyte_in;
      rcrc_ff <= rcrc_in; rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in = state_ff;
      front_in = front_ff; count_in = count_ff; held_in = held_ff; hlen_in = hlen_ff;
      op_in = op_ff; rx_in = rx_ff; idx_in = idx_ff;
      taken_in = taken_ff; data_in = data_ff;
      hcnt_in = hcnt_ff; h2_in = h2_ff; h3_in = h3_ff;
      pos_in = pos_ff; bit_in = bit_ff; crc_in = crc_ff; cbyte_in = cbyte_ff;
      rcrc_in = rcrc_ff;
      rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         cfsr_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tdata[1:0];
               rx_in = req_tdata[9:2];
               idx_in = req_tdata[21:10];
               taken_in = 1'b0;
               data_in = '0;
               state_in = cfsr_pkg::ST_OP;
            end
         end
         cfsr_pkg::ST_OP: begin
            state_in = cfsr_pkg::ST_SCAN;
            unique case (cfsr_pkg::opcode_type'(op_ff))
               cfsr_pkg::OP_PUSH: begin
                  if (count_ff < CW'(cfsr_pkg::BUF_DEPTH)) begin
                     wr_en = 1'b1;
                     count_in = count_ff + 1'b1;
                     taken_in = 1'b1;
                  end
               end
               cfsr_pkg::OP_READ: begin
                  if (held_ff && idx_ff < caplen) begin
                     rd_en = 1'b1;
                     rd_addr = front_ff + AW'(idx_ff) + AW'(4);
                     state_in = cfsr_pkg::ST_RDWAIT;
                  end
               end
               cfsr_pkg::OP_RELEASE: begin
                  if (held_ff) begin
                     front_in = front_ff + AW'(hlen_ff) + AW'(6);
                     count_in = count_ff - CW'(hlen_ff) - CW'(6);
                     held_in = 1'b0;
                     hlen_in = '0;
                  end
               end
               cfsr_pkg::OP_NOP: ;
               default: ;
            endcase
         end
         cfsr_pkg::ST_RDWAIT: begin
            data_in = rd_data_ff;
            state_in = cfsr_pkg::ST_SCAN;
         end
         cfsr_pkg::ST_SCAN: begin
            if (held_ff || count_ff < CW'(4)) state_in = cfsr_pkg::ST_DONE;
            else begin
               hcnt_in = '0;
               state_in = cfsr_pkg::ST_HDR_REQ;
            end
         end
         cfsr_pkg::ST_HDR_REQ: begin
            rd_en = 1'b1;
            rd_addr = front_ff + AW'(hcnt_ff);
            state_in = cfsr_pkg::ST_HDR_WAIT;
         end
         cfsr_pkg::ST_HDR_WAIT: begin
            if (hcnt_ff == 3'd2) h2_in = rd_data_ff;
            if (hcnt_ff == 3'd3) h3_in = rd_data_ff;
            // a bad magic byte ends the header fetch early
            if ((hcnt_ff == 3'd0 && rd_data_ff != magic1_ff) ||
                (hcnt_ff == 3'd1 && rd_data_ff != magic2_ff)) begin
               front_in = front_ff + 1'b1;
               count_in = count_ff - 1'b1;
               state_in = cfsr_pkg::ST_SCAN;
            end else if (hcnt_ff == 3'd3) state_in = cfsr_pkg::ST_HDR_CHECK;
            else begin
               hcnt_in = hcnt_ff + 1'b1;
               state_in = cfsr_pkg::ST_HDR_REQ;
            end
         end
         cfsr_pkg::ST_HDR_CHECK: begin
            if (h2_ff[7:4] != 4'd0 || plen > max_pl_ff ||
                ({1'b0, count_ff} < {1'b0, flen} &&
                 count_ff >= CW'(cfsr_pkg::BUF_DEPTH - 1) &&
                 {1'b0, flen} > (CW+1)'(cfsr_pkg::BUF_DEPTH))) begin
               front_in = front_ff + 1'b1;
               count_in = count_ff - 1'b1;
               state_in = cfsr_pkg::ST_SCAN;
            end else if ({1'b0, count_ff} < {1'b0, flen}) state_in = cfsr_pkg::ST_DONE;
            else begin
               hlen_in = plen;
               pos_in = '0;
               crc_in = cfsr_pkg::CRC_INIT;
               state_in = cfsr_pkg::ST_CRC_REQ;
            end
         end
         cfsr_pkg::ST_CRC_REQ: begin
            rd_en = 1'b1;
            rd_addr = front_ff + AW'(pos_ff);
            state_in = cfsr_pkg::ST_CRC_WAIT;
         end
         cfsr_pkg::ST_CRC_WAIT: begin
            if (pos_ff == crc_n) begin
               rcrc_in[15:8] = rd_data_ff;
               pos_in = pos_ff + 1'b1;
               state_in = cfsr_pkg::ST_CRC_REQ;
            end else if (pos_ff == crc_n + 13'd1) begin
               rcrc_in[7:0] = rd_data_ff;
               state_in = cfsr_pkg::ST_CRC_CMP;
            end else begin
               crc_in = crc_ff ^ {rd_data_ff, 8'h00};
               bit_in = '0;
               state_in = cfsr_pkg::ST_CRC_BIT;
            end
         end
         cfsr_pkg::ST_CRC_BIT: begin
            crc_in = crc_ff[15] ? ({crc_ff[14:0], 1'b0} ^ cfsr_pkg::CRC_POLY)
                                : {crc_ff[14:0], 1'b0};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 3'd7) begin
               pos_in = pos_ff + 1'b1;
               state_in = cfsr_pkg::ST_CRC_REQ;
            end
         end
         cfsr_pkg::ST_CRC_CMP: begin
            if (crc_ff == rcrc_ff) begin
               held_in = 1'b1;
               state_in = cfsr_pkg::ST_DONE;
            end else begin
               hlen_in = '0;
               front_in = front_ff + 1'b1;
               count_in = count_ff - 1'b1;
               state_in = cfsr_pkg::ST_SCAN;
            end
         end
         cfsr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {4'd0, 14'(count_ff), data_ff, caplen, held_ff, taken_ff};
               state_in = cfsr_pkg::ST_IDLE;
            end
         end
         default: state_in = cfsr_pkg::ST_IDLE;
      endcase
   end

   cnt_range_a: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(cfsr_pkg::BUF_DEPTH))
      else $error("fill count exceeds store depth");
   held_len_a: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> ({2'b0, hlen_ff} + 14'd6 <= 14'(count_ff)))
      else $error("held frame longer than stored bytes");
   rsp_ready_a: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !held_ff || state_ff == cfsr_pkg::ST_IDLE)
      else $error("ready outside idle");
   rsp_cap_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[1]) |-> rsp_tdata[13:2] == 12'd0)
      else $error("length reported without held frame");
endmodule
`default_nettype wire
